@@ src/cme_pkg.sv @@
// Package for the cursor motion string expander: widths, character codes,
// the command type that links front and back, and the decimal digit helpers.
// Depends on nothing.
package cme_pkg;

  localparam int CoordBits  = 11;
  localparam int InBits     = 11;
  localparam int CoordMax   = (1 << CoordBits) - 1;
  localparam int DecBits    = 14;
  localparam int DecCap     = 9999;
  localparam int StepBits   = DecBits + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = 1;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [7:0] ChThree   = 8'h33;
  localparam logic [7:0] ChD       = 8'h64;
  localparam logic [7:0] ChI       = 8'h69;
  localparam logic [7:0] ChR       = 8'h72;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [DecBits-1:0]   dec_t;
  typedef logic [StepBits-1:0]  step_t;
  typedef logic [QPtrBits-1:0]  qptr_t;
  typedef logic [QPtrBits:0]    qcnt_t;

  typedef enum logic {
    CmdByte,
    CmdDec
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    dec_t       value;
    logic [1:0] top_pos;
  } cmd_t;

  typedef struct packed {
    logic [3:0] digit;
    dec_t       rest;
  } digit_t;

  function automatic dec_t pow10(logic [1:0] pos);
    dec_t p;
    case (pos)
      2'd0:    p = dec_t'(1);
      2'd1:    p = dec_t'(10);
      2'd2:    p = dec_t'(100);
      default: p = dec_t'(1000);
    endcase
    return p;
  endfunction

  // One decimal digit at position pos, most significant first. The caller
  // keeps rem below ten times the weight of pos.
  function automatic digit_t dec_digit(dec_t rem, logic [1:0] pos);
    step_t  w;
    step_t  step;
    digit_t r;
    w       = step_t'(pow10(pos));
    r.digit = 4'd0;
    r.rest  = rem;
    for (int k = 1; k <= 9; k++) begin
      step = step_t'(k) * w;
      if (step_t'(rem) >= step) begin
        r.digit = 4'(k);
        r.rest  = rem - step[DecBits-1:0];
      end
    end
    return r;
  endfunction

  // Position of the leading digit, given the minimum field width less one.
  function automatic logic [1:0] dec_top(dec_t v, logic [1:0] min_pos);
    logic [1:0] n;
    if (v >= dec_t'(1000))     n = 2'd3;
    else if (v >= dec_t'(100)) n = 2'd2;
    else if (v >= dec_t'(10))  n = 2'd1;
    else                       n = 2'd0;
    return (n > min_pos) ? n : min_pos;
  endfunction

endpackage

@@ src/cme_front.sv @@
// Front part of the cursor motion string expander: accepts template bytes,
// tracks the coordinates and the escape state, and issues output commands.
// Depends on cme_pkg.
module cme_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    template_char_i,
  input  logic          start_flag_i,
  input  logic [10:0]   row_value_i,
  input  logic [10:0]   col_value_i,
  input  logic          q_full_i,
  output logic          push_o,
  output cme_pkg::cmd_t cmd_o
);
  import cme_pkg::*;

  localparam int LoadBits = (CoordBits > InBits) ? CoordBits : InBits;
  localparam int CmpBits  = (CoordBits > DecBits) ? CoordBits : DecBits;

  function automatic coord_t sat_load(logic [InBits-1:0] v);
    logic [LoadBits-1:0] x;
    x = LoadBits'(v);
    return (x > LoadBits'(CoordMax)) ? coord_t'(CoordMax) : x[CoordBits-1:0];
  endfunction

  function automatic dec_t cap_dec(coord_t v);
    logic [CmpBits-1:0] x;
    x = CmpBits'(v);
    return (x > CmpBits'(DecCap)) ? dec_t'(DecCap) : x[DecBits-1:0];
  endfunction

  function automatic coord_t sat_inc(coord_t v);
    return (v == coord_t'(CoordMax)) ? v : coord_t'(v + coord_t'(1));
  endfunction

  coord_t     first_q, first_d;
  coord_t     second_q, second_d;
  logic [1:0] idx_q, idx_d;
  logic       pend_q, pend_d;
  logic       accept;
  logic       push;
  coord_t     take;
  logic [1:0] min_pos;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept && push;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    push     = 1'b0;
    min_pos  = 2'd0;
    cmd_o    = '{kind: CmdByte, ch: template_char_i, value: '0, top_pos: 2'd0};

    if (start_flag_i) begin
      first_d  = sat_load(row_value_i);
      second_d = sat_load(col_value_i);
      idx_d    = 2'd0;
      pend_d   = 1'b0;
    end

    take = (idx_d == 2'd0) ? first_d : second_d;

    if (template_char_i == ChNul) begin
      pend_d = 1'b0;
    end else if (!pend_d) begin
      if (template_char_i == ChPercent) pend_d = 1'b1;
      else                              push   = 1'b1;
    end else begin
      pend_d = 1'b0;
      unique case (template_char_i) inside
        ChPercent: begin
          push = 1'b1;
        end
        ChD, ChTwo, ChThree: begin
          if (template_char_i == ChThree)    min_pos = 2'd2;
          else if (template_char_i == ChTwo) min_pos = 2'd1;
          if (idx_d < 2'd2) begin
            push          = 1'b1;
            cmd_o.kind    = CmdDec;
            cmd_o.value   = cap_dec(take);
            cmd_o.top_pos = dec_top(cap_dec(take), min_pos);
            idx_d         = idx_d + 2'd1;
          end
        end
        ChDot: begin
          if (idx_d < 2'd2) begin
            idx_d    = idx_d + 2'd1;
            cmd_o.ch = 8'(take);
            push     = (8'(take) != 8'd0);
          end
        end
        ChR: begin
          {first_d, second_d} = {second_d, first_d};
        end
        ChI: begin
          first_d  = sat_inc(first_d);
          second_d = sat_inc(second_d);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      idx_q    <= 2'd0;
      pend_q   <= 1'b0;
    end else if (accept) begin
      first_q  <= first_d;
      second_q <= second_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
    end
  end

endmodule

@@ src/cme_queue.sv @@
// Short command queue between the front and the back of the expander.
// Depends on cme_pkg.
module cme_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cme_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output cme_pkg::cmd_t head_o
);
  import cme_pkg::*;

  cmd_t  mem_q [QueueDepth];
  qptr_t wr_ptr_q;
  qptr_t rd_ptr_q;
  qcnt_t cnt_q;
  logic  do_push;
  logic  do_pop;

  assign full_o       = (cnt_q == qcnt_t'(QueueDepth));
  assign head_valid_o = (cnt_q != qcnt_t'(0));
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + qptr_t'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + qptr_t'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + qcnt_t'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - qcnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

@@ src/cme_back.sv @@
// Back part of the expander: carries out queued commands and drives the
// output register, one byte per cycle while not stalled, decimal digits most significant first.
// Depends on cme_pkg.
module cme_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  cme_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          last_of_run_o
);
  import cme_pkg::*;

  logic       act_q, act_d;
  dec_t       rem_q, rem_d;
  logic [1:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       load;
  dec_t       src_rem;
  logic [1:0] src_pos;
  digit_t     dg;

  assign load    = !out_valid_q || !out_stall_i;
  assign src_rem = act_q ? rem_q : head_i.value;
  assign src_pos = act_q ? pos_q : head_i.top_pos;
  assign dg      = dec_digit(src_rem, src_pos);
  assign pop_o   = load && !act_q && head_valid_i;

  always_comb begin
    act_d       = act_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = act_q || head_valid_i;
      if (act_q || (head_valid_i && head_i.kind == CmdDec)) begin
        out_char_d = ChZero + {4'b0000, dg.digit};
        out_last_d = (src_pos == 2'd0);
        act_d      = (src_pos != 2'd0);
        rem_d      = dg.rest;
        pos_d      = src_pos - 2'd1;
      end else if (head_valid_i) begin
        out_char_d = head_i.ch;
        out_last_d = 1'b1;
        act_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;

endmodule

@@ src/cursor_motion_string_expander.sv @@
// Cursor motion string expander. A result byte passes from its accepted
// template item through the command queue and the back end's output register.
// Plain bytes go at one item per cycle while neither queue nor output stalls;
// a decimal number (at most four digits) holds the back end until its last digit is out.
// The two-entry command queue sets how far the front may run ahead of the back.
// Reset (rst_ni low, asynchronous) clears coordinates, escape state, queue and back end.
module cursor_motion_string_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  template_char_i,
  input  logic        start_flag_i,
  input  logic [10:0] row_value_i,
  input  logic [10:0] col_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o
);
  import cme_pkg::*;

  // The front decodes each item in the cycle it is accepted. Escapes that
  // only change state (swap, increment, dropped letters, a lone percent sign)
  // leave nothing in the queue; everything that prints becomes one command.
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  cme_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .template_char_i (template_char_i),
    .start_flag_i    (start_flag_i),
    .row_value_i     (row_value_i),
    .col_value_i     (col_value_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // The queue lets the front keep taking items while the back is busy
  // spelling out a number or waiting on a stalled output.
  cme_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // The back emits one byte a cycle into its output register while the output is not
  // stalled. The final byte of each command carries last_of_run.
  cme_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ src/cme_checker.sv @@
// Port-level checks for the cursor motion string expander, bound to the top.
// Depends on cursor_motion_string_expander.
module cme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  template_char_i,
  input logic        start_flag_i,
  input logic [10:0] row_value_i,
  input logic [10:0] col_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_char_o,
  input logic        last_of_run_o
);

  // A stalled result item keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o)
      && $stable(last_of_run_o))
    else $error("stalled output item changed");

  // Only a decimal conversion produces more than one byte per item.
  a_digit_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> out_char_o >= 8'h30 && out_char_o <= 8'h39)
    else $error("non-final byte is not a decimal digit");

  // The digits of one number leave without a gap.
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a decimal run");

  // Nothing is offered on the first cycle out of reset.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind cursor_motion_string_expander cme_checker u_cme_checker (.*);
